// ----- sv/sfr_pkg.sv -----
// Shared types, constants and helpers for the stream find-and-replace block.
// No dependencies; imported by sfr_window and stream_find_replace.
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int REG_BYTES   = 8;   // bytes held in one pattern/replace register

    localparam int PLEN_CAP  = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int RLEN_CAP  = (MAX_REPLACE < REG_BYTES) ? MAX_REPLACE : REG_BYTES;
    localparam int LEN_W     = 4;
    localparam int WIN_IDX_W = (PLEN_CAP > 1) ? $clog2(PLEN_CAP) : 1;
    localparam int BURST_MAX = REG_BYTES;
    localparam int DATA_W    = 8 * REG_BYTES;

    typedef enum logic [7:0] {
        REG_PATTERN_LEN   = 8'd0,
        REG_PATTERN_BYTES = 8'd1,
        REG_REPLACE_LEN   = 8'd2,
        REG_REPLACE_BYTES = 8'd3
    } cfg_reg_t;

    // Result bytes caused by one input request, drained one per cycle while the output stream is ready.
    typedef struct packed {
        logic [DATA_W-1:0] bytes;     // first byte in bits 7..0
        logic [LEN_W-1:0]  count;     // number of result items, 0..BURST_MAX
        logic              last;      // final item of the burst ends the text
        logic              has_data;  // 0 for the empty end marker
    } burst_t;

    function automatic logic [LEN_W-1:0] pat_len_eff(input logic [LEN_W-1:0] v);
        if (v == '0)
            return LEN_W'(1);
        else if (v > LEN_W'(PLEN_CAP))
            return LEN_W'(PLEN_CAP);
        else
            return v;
    endfunction

    function automatic logic [LEN_W-1:0] rep_len_eff(input logic [LEN_W-1:0] v);
        if (v > LEN_W'(RLEN_CAP))
            return LEN_W'(RLEN_CAP);
        else
            return v;
    endfunction

endpackage

// ----- sv/sfr_window.sv -----
// Sliding match window: holds up to pattern-length bytes and works out the
// burst of result bytes for each accepted request. Depends on sfr_pkg.
module sfr_window
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  logic              clear,
    input  logic [LEN_W-1:0]  plen,
    input  logic [DATA_W-1:0] pattern_bytes,
    input  logic [LEN_W-1:0]  rlen,
    input  logic [DATA_W-1:0] replace_bytes,
    output burst_t            burst
);

    logic [7:0]       win_reg  [PLEN_CAP];
    logic [7:0]       win_next [PLEN_CAP];
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_next;

    logic [7:0]        w [PLEN_CAP];
    logic [LEN_W-1:0]  base;
    logic [LEN_W-1:0]  cnt1;
    logic              full;
    logic              match;
    logic [DATA_W-1:0] w_packed;

    always_comb
    begin
        base = (cnt_reg >= plen) ? '0 : cnt_reg;
        w = win_reg;
        w[base[WIN_IDX_W-1:0]] = text_byte;
        cnt1 = base + LEN_W'(1);
        full = (cnt1 == plen);

        match = 1'b1;
        w_packed = '0;
        for (int i = 0; i < PLEN_CAP; i++)
        begin
            w_packed[8*i +: 8] = w[i];
            if ((LEN_W'(i) < plen) && (w[i] != pattern_bytes[8*i +: 8]))
                match = 1'b0;
        end

        burst.bytes    = w_packed;
        burst.count    = '0;
        burst.last     = end_of_text;
        burst.has_data = 1'b1;
        win_next = w;
        cnt_next = cnt1;

        if (full && match)
        begin
            burst.bytes = replace_bytes;
            burst.count = rlen;
            cnt_next    = '0;
        end
        else if (full)
        begin
            // oldest byte leaves; on the final byte the whole window goes out
            burst.count = end_of_text ? plen : LEN_W'(1);
            for (int i = 0; i < PLEN_CAP - 1; i++)
                win_next[i] = w[i+1];
            cnt_next = plen - LEN_W'(1);
        end
        else if (end_of_text)
        begin
            burst.count = cnt1;
        end

        if (end_of_text)
        begin
            cnt_next = '0;
            if (burst.count == '0)
            begin
                burst.count    = LEN_W'(1);
                burst.has_data = 1'b0;
                burst.bytes    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (clear)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

endmodule

// ----- sv/stream_find_replace.sv -----
// Top level of the stream find-and-replace block: configuration registers,
// input handshake and the output burst register. Depends on sfr_pkg, sfr_window.
//
// Text bytes enter on the s_ stream, tlast on the final byte. Every leftmost,
// non-overlapping occurrence of the pattern (1..8 bytes) is replaced by the
// replacement (0..8 bytes); the rewritten text leaves on the m_ stream, tuser
// high for a real byte and low for the empty end marker, tlast on the final
// item of the text. While m_tready is high, a request that yields at most one
// byte does not stall the input, so ordinary text streams at one byte per cycle;
// a request that yields n bytes (replacement or end-of-text flush) stalls the
// input while the single output burst register drains one byte per cycle, and
// the next request is taken as the last byte of the burst leaves.
// The user must write configuration on the cfg_ port only while the block is
// idle; the block does not enforce this. A pattern length write empties the window.
module stream_find_replace
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast,   // last_out

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [LEN_W-1:0]  pattern_len_reg;
    logic [DATA_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0]  replace_len_reg;
    logic [DATA_W-1:0] replace_bytes_reg;

    logic [DATA_W-1:0] obytes_reg;
    logic [LEN_W-1:0]  ocnt_reg;
    logic              olast_reg;
    logic              ovalid_reg;

    logic   cfg_write;
    logic   clear_window;
    logic   in_accept;
    logic   out_take;
    burst_t burst;

    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign clear_window = cfg_write && (cfg_index == REG_PATTERN_LEN);

    assign m_tvalid  = (ocnt_reg != '0);
    assign out_take  = m_tvalid && m_tready;
    assign s_tready  = (ocnt_reg == '0) || ((ocnt_reg == LEN_W'(1)) && m_tready);
    assign in_accept = s_tvalid && s_tready;

    assign m_tdata = obytes_reg[7:0];
    assign m_tuser = ovalid_reg;
    assign m_tlast = olast_reg && (ocnt_reg == LEN_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= LEN_W'(1);
            pattern_bytes_reg <= '0;
            replace_len_reg   <= '0;
            replace_bytes_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[LEN_W-1:0];
                REG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data[DATA_W-1:0];
                REG_REPLACE_LEN:   replace_len_reg   <= cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES: replace_bytes_reg <= cfg_data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    sfr_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .text_byte     (s_tdata),
        .end_of_text   (s_tlast),
        .clear         (clear_window),
        .plen          (pat_len_eff(pattern_len_reg)),
        .pattern_bytes (pattern_bytes_reg),
        .rlen          (rep_len_eff(replace_len_reg)),
        .replace_bytes (replace_bytes_reg),
        .burst         (burst)
    );

    // a request that yields nothing leaves the burst register alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ocnt_reg <= '0;
        else if (in_accept && (burst.count != '0))
            ocnt_reg <= burst.count;
        else if (out_take)
            ocnt_reg <= ocnt_reg - LEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (burst.count != '0))
        begin
            obytes_reg <= burst.bytes;
            olast_reg  <= burst.last;
            ovalid_reg <= burst.has_data;
        end
        else if (out_take)
        begin
            obytes_reg <= {8'h00, obytes_reg[DATA_W-1:8]};
        end
    end

endmodule

// ----- dv/tb_stream_find_replace.sv -----
`timescale 1ns / 100ps
// Testbench for stream_find_replace: sends text and register writes, predicts the
// rewritten byte stream in SystemVerilog and checks each result in order.
// Depends on sfr_pkg and the stream_find_replace RTL.
module tb_stream_find_replace;
    import sfr_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         LONG_HOLD      = 300;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         RANDOM_ITEMS   = 220;
    localparam int         PHASE_ITEMS    = 35;
    localparam int         MAX_REPORTS    = 10;
    localparam logic [7:0] IDX_UNUSED_LO  = 8'h04;
    localparam logic [7:0] IDX_UNUSED_HI  = 8'hFF;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } text_out_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    // predictor copy of the registers and the match window
    logic [3:0]  pat_len_reg = 4'd1;
    logic [63:0] pat_reg     = '0;
    logic [3:0]  rep_len_reg = '0;
    logic [63:0] rep_reg     = '0;
    logic [7:0]  win [MAX_PATTERN] = '{default: 8'h00};
    int unsigned win_cnt     = 0;

    text_out_t   expected_q [$];
    logic [7:0]  src_text [$];
    int          err_cnt     = 0;
    int          idle_cycles = 0;
    int          hold_req    = 0;
    bit          no_gaps     = 1'b0;

    stream_find_replace u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned eff_pat_len(input logic [3:0] v);
        if (v == 4'd0)
            return 1;
        if (v > MAX_PATTERN)
            return MAX_PATTERN;
        return v;
    endfunction

    function automatic int unsigned eff_rep_len(input logic [3:0] v);
        return (v > MAX_REPLACE) ? MAX_REPLACE : v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Expected output bytes for one accepted text byte.
    task automatic rewrite_byte(input logic [7:0] b, input logic end_text);
        text_out_t   burst [$];
        text_out_t   tail;
        int unsigned plen;
        int unsigned rlen;
        bit          hit;
        plen = eff_pat_len(pat_len_reg);
        rlen = eff_rep_len(rep_len_reg);
        if (win_cnt >= plen)
            win_cnt = 0;
        win[win_cnt] = b;
        win_cnt++;
        if (win_cnt == plen)
        begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++)
                if (win[i] != pat_reg[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (int i = 0; i < rlen; i++)
                    burst.push_back(text_out_t'{rep_reg[8*i +: 8], 1'b1, 1'b0});
                win_cnt = 0;
            end
            else
            begin
                burst.push_back(text_out_t'{win[0], 1'b1, 1'b0});
                for (int i = 0; i + 1 < plen; i++)
                    win[i] = win[i+1];
                win_cnt--;
            end
        end
        if (end_text)
        begin
            for (int i = 0; i < win_cnt; i++)
                burst.push_back(text_out_t'{win[i], 1'b1, 1'b0});
            win_cnt = 0;
            // nothing left to send: an empty marker closes the text
            if (burst.size() == 0)
                burst.push_back(text_out_t'{8'h00, 1'b0, 1'b0});
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i])
            expected_q.push_back(burst[i]);
    endtask

    always @(posedge clk)
    begin : scoreboard
        text_out_t got;
        text_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_LEN:
                    begin
                        pat_len_reg = cfg_data[3:0];
                        win_cnt = 0;
                    end
                    REG_PATTERN_BYTES: pat_reg = cfg_data;
                    REG_REPLACE_LEN:   rep_len_reg = cfg_data[3:0];
                    REG_REPLACE_BYTES: rep_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                rewrite_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got = text_out_t'{m_tdata, m_tuser, m_tlast};
                if (expected_q.size() == 0)
                    report_error($sformatf("unexpected result: byte %h valid %b last %b",
                                           got.data, got.valid, got.last));
                else
                begin
                    want = expected_q.pop_front();
                    if (got.data !== want.data || got.valid !== want.valid ||
                        got.last !== want.last)
                        report_error($sformatf(
                            "mismatch: exp byte %h valid %b last %b, got byte %h valid %b last %b",
                            want.data, want.valid, want.last, got.data, got.valid, got.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin : sink
        int gap;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                gap = hold_req;
                hold_req = 0;
            end
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic end_text);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= end_text;
        do @(posedge clk); while (s_tready !== 1'b1);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input logic end_text);
        foreach (src_text[i])
            send_byte(src_text[i], end_text && (i == src_text.size() - 1));
        src_text.delete();
    endtask

    // Waits for every expected byte, then lets requests that emit nothing settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    task automatic set_config(input logic [3:0] plen, input logic [63:0] pat,
                              input logic [3:0] rlen, input logic [63:0] rep);
        logic [63:0] noise;
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_REPLACE_BYTES, rep);
        // only the low nibble of a length write counts
        noise = {$urandom, $urandom};
        write_reg(REG_PATTERN_LEN, {noise[63:4], plen});
        noise = {$urandom, $urandom};
        write_reg(REG_REPLACE_LEN, {noise[63:4], rlen});
        cfg_valid <= 1'b0;
    endtask

    // Text biased toward full and partial copies of the pattern.
    task automatic build_text(input int n, input int unsigned plen, input logic [63:0] pat);
        int k;
        int cut;
        while (src_text.size() < n)
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
            begin
                cut = (k < 3) ? plen : $urandom_range(1, plen);
                for (int i = 0; i < cut; i++)
                    src_text.push_back(pat[8*i +: 8]);
            end
            else if (k < 8)
            begin
                cut = $urandom_range(0, plen - 1);
                src_text.push_back(pat[8*cut +: 8]);
            end
            else
                src_text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_reset_defaults();
        // one-byte pattern 00 with an empty replacement: zero bytes vanish
        src_text = '{8'h00, 8'h41, 8'h00};
        send_text(1'b1);
        src_text = '{8'hFF};
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_directed_cases();
        // "ab" -> "XYZ": overlap in "aab", match on the final byte, held byte flushed
        set_config(4'd2, 64'h6261, 4'd3, 64'h5A5958);
        src_text = '{8'h61, 8'h61, 8'h62, 8'h78, 8'h61, 8'h62};
        send_text(1'b1);
        src_text = '{8'h62, 8'h61};
        send_text(1'b1);
        wait_idle();
        // oversized lengths clip to eight bytes
        set_config(4'd15, 64'hFF00_FF00_FF00_FF00, 4'd15, 64'h0123_4567_89AB_CDEF);
        src_text = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_text(1'b1);
        wait_idle();
        // zero pattern length behaves as one
        set_config(4'd0, 64'h61, 4'd2, 64'h3E3C);
        src_text = '{8'h62, 8'h61};
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_len_rewrite();
        set_config(4'd3, 64'h636261, 4'd1, 64'h2A);
        src_text = '{8'h61, 8'h62};
        send_text(1'b0);
        wait_idle();
        // held "ab" is dropped, so the following "c" cannot complete a match
        write_reg(REG_PATTERN_LEN, 64'd3);
        cfg_valid <= 1'b0;
        src_text = '{8'h63};
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_unused_index();
        write_reg(IDX_UNUSED_LO, '1);
        write_reg(IDX_UNUSED_HI, '1);
        cfg_valid <= 1'b0;
        src_text = '{8'h61, 8'h62, 8'h63};
        send_text(1'b1);
        wait_idle();
    endtask

    task automatic test_output_stall();
        set_config(4'd2, 64'h6261, 4'd8, {$urandom, $urandom});
        no_gaps = 1'b1;
        hold_req = LONG_HOLD;
        for (int i = 0; i < 40; i++)
            src_text.push_back((i % 2 == 0) ? 8'h61 : 8'h62);
        send_text(1'b1);
        wait_idle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_text();
        int          sent;
        int          phase;
        int          phase_bytes;
        int          r;
        logic [3:0]  plen_v;
        logic [3:0]  rlen_v;
        logic [63:0] pat_v;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if (phase == 0)
            begin
                plen_v = 4'd8;
                rlen_v = 4'd0;
            end
            else if (phase == 1)
            begin
                plen_v = 4'd1;
                rlen_v = 4'd8;
            end
            else
            begin
                r = $urandom_range(0, 9);
                plen_v = (r == 0) ? 4'd0 :
                         (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
                r = $urandom_range(0, 9);
                rlen_v = (r < 2) ? 4'd0 :
                         (r == 2) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
            end
            // small alphabet half the time so repeats and overlaps show up
            for (int i = 0; i < 8; i++)
                pat_v[8*i +: 8] = ($urandom_range(0, 1) == 1) ?
                                  8'($urandom_range(8'h61, 8'h62)) : 8'($urandom);
            set_config(plen_v, pat_v, rlen_v, {$urandom, $urandom});
            no_gaps = (phase % 3 == 2);
            phase_bytes = 0;
            while (phase_bytes < PHASE_ITEMS)
            begin
                build_text($urandom_range(1, 14), eff_pat_len(plen_v), pat_v);
                phase_bytes += src_text.size();
                send_text(1'b1);
            end
            sent += phase_bytes;
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : test_sequence
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_len_rewrite();
        test_unused_index();
        test_output_stall();
        test_random_text();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
